/* sv/rtbt_pkg.sv */
package rtbt_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int FRAC_BITS     = 16;
    localparam int EPS_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int NUM_WIDTH     = 2 * COORD_WIDTH + 2;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [NUM_WIDTH-1:0]   t_num;

    localparam t_coord C_MAX       = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord C_MIN       = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam t_coord C_ONE       = t_coord'(1) <<< FRAC_BITS;
    localparam t_coord C_MINUS_ONE = -C_ONE;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_ORIGIN_X,
        CFG_ORIGIN_Y,
        CFG_ORIGIN_Z,
        CFG_DIR_X,
        CFG_DIR_Y,
        CFG_DIR_Z,
        CFG_EPSILON
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_HIT,
        ST_PARALLEL,
        ST_U_OUT,
        ST_V_OUT,
        ST_BEHIND
    } t_status;

    typedef struct packed {
        t_coord vert0_x;
        t_coord vert0_y;
        t_coord vert0_z;
        t_coord vert1_x;
        t_coord vert1_y;
        t_coord vert1_z;
        t_coord vert2_x;
        t_coord vert2_y;
        t_coord vert2_z;
    } t_tri_in;

    typedef struct packed {
        logic       hit;
        logic [2:0] status;
        t_coord     bary_u;
        t_coord     bary_v;
        t_coord     bary_w;
        t_coord     dist_t;
    } t_result;

    typedef struct packed {
        t_coord origin_x;
        t_coord origin_y;
        t_coord origin_z;
        t_coord dir_x;
        t_coord dir_y;
        t_coord dir_z;
    } t_ray;

    typedef struct packed {
        t_coord a;
        t_num   num_u;
        t_num   num_v;
        t_num   num_t;
    } t_geom;

endpackage

/* sv/rtbt_geom.sv */
module rtbt_geom (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  rtbt_pkg::t_tri_in i_tri,
    input  rtbt_pkg::t_ray  i_ray,
    output logic            o_vld,
    output rtbt_pkg::t_geom o_geom
);
    import rtbt_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;

    typedef logic signed [PW-1:0] t_prod;

    function automatic t_coord sat_sub(t_coord x, t_coord y);
        logic signed [W:0] d;
        d = $signed({x[W-1], x}) - $signed({y[W-1], y});
        if (d[W] != d[W-1]) begin
            sat_sub = d[W] ? C_MIN : C_MAX;
        end else begin
            sat_sub = d[W-1:0];
        end
    endfunction

    function automatic t_coord cross_sat(t_prod p, t_prod m);
        logic signed [PW:0] d;
        logic signed [PW:0] sh;
        d  = $signed({p[PW-1], p}) - $signed({m[PW-1], m});
        sh = d >>> F;
        if ((&sh[PW:W-1]) || !(|sh[PW:W-1])) begin
            cross_sat = sh[W-1:0];
        end else begin
            cross_sat = sh[PW] ? C_MIN : C_MAX;
        end
    endfunction

    function automatic t_coord num_sat(t_num x);
        t_num sh;
        sh = x >>> F;
        if ((&sh[NUM_WIDTH-1:W-1]) || !(|sh[NUM_WIDTH-1:W-1])) begin
            num_sat = sh[W-1:0];
        end else begin
            num_sat = sh[NUM_WIDTH-1] ? C_MIN : C_MAX;
        end
    endfunction

    t_coord v0 [3];
    t_coord v1 [3];
    t_coord v2 [3];
    t_coord org [3];
    t_coord dir [3];

    assign v0[0]  = i_tri.vert0_x;
    assign v0[1]  = i_tri.vert0_y;
    assign v0[2]  = i_tri.vert0_z;
    assign v1[0]  = i_tri.vert1_x;
    assign v1[1]  = i_tri.vert1_y;
    assign v1[2]  = i_tri.vert1_z;
    assign v2[0]  = i_tri.vert2_x;
    assign v2[1]  = i_tri.vert2_y;
    assign v2[2]  = i_tri.vert2_z;
    assign org[0] = i_ray.origin_x;
    assign org[1] = i_ray.origin_y;
    assign org[2] = i_ray.origin_z;
    assign dir[0] = i_ray.dir_x;
    assign dir[1] = i_ray.dir_y;
    assign dir[2] = i_ray.dir_z;

    logic   r_vld [5];
    t_coord r1_e1 [3];
    t_coord r1_e2 [3];
    t_coord r1_s  [3];
    t_prod  r2_hp [6];
    t_prod  r2_qp [6];
    t_coord r2_e1 [3];
    t_coord r2_e2 [3];
    t_coord r2_s  [3];
    t_coord r3_h  [3];
    t_coord r3_q  [3];
    t_coord r3_e1 [3];
    t_coord r3_e2 [3];
    t_coord r3_s  [3];
    t_prod  r4_pa [3];
    t_prod  r4_pu [3];
    t_prod  r4_pv [3];
    t_prod  r4_pt [3];
    t_geom  r5_geom;

    t_coord n1_e1 [3];
    t_coord n1_e2 [3];
    t_coord n1_s  [3];
    t_prod  n2_hp [6];
    t_prod  n2_qp [6];
    t_coord n3_h  [3];
    t_coord n3_q  [3];
    t_prod  n4_pa [3];
    t_prod  n4_pu [3];
    t_prod  n4_pv [3];
    t_prod  n4_pt [3];
    t_geom  n5_geom;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_e1[i] = sat_sub(v1[i], v0[i]);
            n1_e2[i] = sat_sub(v2[i], v0[i]);
            n1_s[i]  = sat_sub(org[i], v0[i]);
        end
    end

    always_comb begin
        n2_hp[0] = t_prod'(dir[1]) * t_prod'(r1_e2[2]);
        n2_hp[1] = t_prod'(dir[2]) * t_prod'(r1_e2[1]);
        n2_hp[2] = t_prod'(dir[2]) * t_prod'(r1_e2[0]);
        n2_hp[3] = t_prod'(dir[0]) * t_prod'(r1_e2[2]);
        n2_hp[4] = t_prod'(dir[0]) * t_prod'(r1_e2[1]);
        n2_hp[5] = t_prod'(dir[1]) * t_prod'(r1_e2[0]);
        n2_qp[0] = t_prod'(r1_s[1]) * t_prod'(r1_e1[2]);
        n2_qp[1] = t_prod'(r1_s[2]) * t_prod'(r1_e1[1]);
        n2_qp[2] = t_prod'(r1_s[2]) * t_prod'(r1_e1[0]);
        n2_qp[3] = t_prod'(r1_s[0]) * t_prod'(r1_e1[2]);
        n2_qp[4] = t_prod'(r1_s[0]) * t_prod'(r1_e1[1]);
        n2_qp[5] = t_prod'(r1_s[1]) * t_prod'(r1_e1[0]);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_h[i] = cross_sat(r2_hp[2*i], r2_hp[2*i+1]);
            n3_q[i] = cross_sat(r2_qp[2*i], r2_qp[2*i+1]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n4_pa[i] = t_prod'(r3_e1[i]) * t_prod'(r3_h[i]);
            n4_pu[i] = t_prod'(r3_s[i]) * t_prod'(r3_h[i]);
            n4_pv[i] = t_prod'(dir[i]) * t_prod'(r3_q[i]);
            n4_pt[i] = t_prod'(r3_e2[i]) * t_prod'(r3_q[i]);
        end
    end

    t_num sum_a;

    always_comb begin
        sum_a = t_num'(r4_pa[0]) + t_num'(r4_pa[1]) + t_num'(r4_pa[2]);
        n5_geom.a     = num_sat(sum_a);
        n5_geom.num_u = t_num'(r4_pu[0]) + t_num'(r4_pu[1]) + t_num'(r4_pu[2]);
        n5_geom.num_v = t_num'(r4_pv[0]) + t_num'(r4_pv[1]) + t_num'(r4_pv[2]);
        n5_geom.num_t = t_num'(r4_pt[0]) + t_num'(r4_pt[1]) + t_num'(r4_pt[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int i = 1; i < 5; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_e1 <= n1_e1;
        r1_e2 <= n1_e2;
        r1_s  <= n1_s;
        r2_hp <= n2_hp;
        r2_qp <= n2_qp;
        r2_e1 <= r1_e1;
        r2_e2 <= r1_e2;
        r2_s  <= r1_s;
        r3_h  <= n3_h;
        r3_q  <= n3_q;
        r3_e1 <= r2_e1;
        r3_e2 <= r2_e2;
        r3_s  <= r2_s;
        r4_pa <= n4_pa;
        r4_pu <= n4_pu;
        r4_pv <= n4_pv;
        r4_pt <= n4_pt;
        r5_geom <= n5_geom;
    end

    assign o_vld  = r_vld[4];
    assign o_geom = r5_geom;

endmodule

/* sv/rtbt_div.sv */
module rtbt_div (
    input  logic             i_clk,
    input  rtbt_pkg::t_num   i_num,
    input  rtbt_pkg::t_coord i_den,
    output rtbt_pkg::t_coord o_quo
);
    import rtbt_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int NW = NUM_WIDTH;

    logic [W-1:0] r_rem [W+1];
    logic [W-1:0] r_lo  [W+1];
    logic [W-1:0] r_q   [W+1];
    logic [W-1:0] r_d   [W+1];
    logic         r_neg [W+1];
    logic         r_ovf [W+1];
    t_coord       r_quo;

    logic          n_neg;
    logic [NW-1:0] n_nmag;
    logic [W-1:0]  n_dmag;
    logic [W+1:0]  n_hi;

    always_comb begin
        n_neg  = i_num[NW-1] ^ i_den[W-1];
        n_nmag = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
        n_dmag = i_den[W-1] ? W'(-i_den) : W'(i_den);
        n_hi   = n_nmag[NW-1:W];
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= n_hi[W-1:0];
        r_lo[0]  <= n_nmag[W-1:0];
        r_q[0]   <= '0;
        r_d[0]   <= n_dmag;
        r_neg[0] <= n_neg;
        r_ovf[0] <= n_hi >= {2'b00, n_dmag};
    end

    for (genvar k = 1; k <= W; k++) begin : g_step
        logic [W:0] n_rem2;
        logic [W:0] n_diff;
        logic       n_ge;

        always_comb begin
            n_rem2 = {r_rem[k-1], r_lo[k-1][W-1]};
            n_diff = n_rem2 - {1'b0, r_d[k-1]};
            n_ge   = n_rem2 >= {1'b0, r_d[k-1]};
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_ge ? n_diff[W-1:0] : n_rem2[W-1:0];
            r_lo[k]  <= {r_lo[k-1][W-2:0], 1'b0};
            r_q[k]   <= {r_q[k-1][W-2:0], n_ge};
            r_d[k]   <= r_d[k-1];
            r_neg[k] <= r_neg[k-1];
            r_ovf[k] <= r_ovf[k-1];
        end
    end

    logic [W:0] n_lim;
    logic       n_sat;

    always_comb begin
        n_lim = {2'b00, {(W-1){1'b1}}} + {{W{1'b0}}, r_neg[W]};
        n_sat = r_ovf[W] || ({1'b0, r_q[W]} > n_lim);
    end

    always_ff @(posedge i_clk) begin
        if (n_sat) begin
            r_quo <= r_neg[W] ? C_MIN : C_MAX;
        end else begin
            r_quo <= r_neg[W] ? t_coord'(-r_q[W]) : t_coord'(r_q[W]);
        end
    end

    assign o_quo = r_quo;

endmodule

/* sv/ray_triangle_barycentric_test_top.sv */
// Ray against triangle intersection test, one triangle per request.
// Before a ray is traced, its origin, direction and tolerance are written
// through the register port (i_cfg_we, i_cfg_idx, i_cfg_data) while no
// request is in flight. Each triangle request is taken at a clock edge at
// which start is high and busy is low; busy is always low, so a new
// triangle may be presented in every cycle.
// The result appears on o_res with o_strobe high for one cycle, and results
// leave in the order in which requests came in. Throughput is one triangle
// per cycle. The pipeline has five stages of edge, cross product and dot
// product arithmetic, then three pipelined dividers that take one stage to
// set up, retire one quotient bit per stage and take one stage to saturate,
// then one stage that picks the status and the saturated fields.
// The receiver cannot hold results off, so the pipeline never stalls.
// Reset clears all valid bits in flight and returns the registers to a ray
// from the origin along the x axis with a tolerance of seven.
module ray_triangle_barycentric_test_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    input  rtbt_pkg::t_tri_in                    i_tri,
    input  logic                                 i_cfg_we,
    input  logic [rtbt_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_idx,
    input  logic [rtbt_pkg::COORD_WIDTH-1:0]     i_cfg_data,
    output logic                                 busy,
    output logic                                 o_strobe,
    output rtbt_pkg::t_result                    o_res
);
    import rtbt_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int CW = W + 3;
    localparam int DL = W + 2;

    localparam logic signed [CW-1:0] ONE_E = CW'(1) <<< FRAC_BITS;
    localparam logic signed [CW-1:0] MAX_E = {3'b000, C_MAX};
    localparam logic signed [CW-1:0] MIN_E = {3'b111, C_MIN};

    t_ray                 r_ray;
    logic [EPS_WIDTH-1:0] r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray.origin_x <= '0;
            r_ray.origin_y <= '0;
            r_ray.origin_z <= '0;
            r_ray.dir_x    <= C_ONE;
            r_ray.dir_y    <= '0;
            r_ray.dir_z    <= '0;
            r_eps          <= EPS_WIDTH'(7);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X: r_ray.origin_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_ray.origin_y <= i_cfg_data;
                CFG_ORIGIN_Z: r_ray.origin_z <= i_cfg_data;
                CFG_DIR_X:    r_ray.dir_x    <= i_cfg_data;
                CFG_DIR_Y:    r_ray.dir_y    <= i_cfg_data;
                CFG_DIR_Z:    r_ray.dir_z    <= i_cfg_data;
                CFG_EPSILON:  r_eps          <= i_cfg_data[EPS_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic  geom_vld;
    t_geom geom;

    rtbt_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start & ~busy),
        .i_tri   (i_tri),
        .i_ray   (r_ray),
        .o_vld   (geom_vld),
        .o_geom  (geom)
    );

    t_coord quo_u;
    t_coord quo_v;
    t_coord quo_t;

    rtbt_div u_div_u (.i_clk(i_clk), .i_num(geom.num_u), .i_den(geom.a), .o_quo(quo_u));
    rtbt_div u_div_v (.i_clk(i_clk), .i_num(geom.num_v), .i_den(geom.a), .o_quo(quo_v));
    rtbt_div u_div_t (.i_clk(i_clk), .i_num(geom.num_t), .i_den(geom.a), .o_quo(quo_t));

    logic signed [CW-1:0] eps_e;
    logic signed [CW-1:0] a_e;
    logic                 n_par;

    always_comb begin
        eps_e = $signed({{(CW-EPS_WIDTH){1'b0}}, r_eps});
        a_e   = CW'(geom.a);
        n_par = (geom.a == '0) || ((a_e > -eps_e) && (a_e < eps_e));
    end

    logic r_side_vld [DL];
    logic r_side_par [DL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DL; i++) begin
                r_side_vld[i] <= 1'b0;
            end
        end else begin
            r_side_vld[0] <= geom_vld;
            for (int i = 1; i < DL; i++) begin
                r_side_vld[i] <= r_side_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_side_par[0] <= n_par;
        for (int i = 1; i < DL; i++) begin
            r_side_par[i] <= r_side_par[i-1];
        end
    end

    logic signed [CW-1:0] u_e;
    logic signed [CW-1:0] v_e;
    logic signed [CW-1:0] t_e;
    logic signed [CW-1:0] w_e;
    t_coord               n_w;
    t_status              n_status;
    t_result              n_res;

    always_comb begin
        u_e = CW'(quo_u);
        v_e = CW'(quo_v);
        t_e = CW'(quo_t);
        w_e = ONE_E - u_e - v_e;
        if (w_e > MAX_E) begin
            n_w = C_MAX;
        end else if (w_e < MIN_E) begin
            n_w = C_MIN;
        end else begin
            n_w = w_e[W-1:0];
        end

        n_res.bary_u = C_MINUS_ONE;
        n_res.bary_v = C_MINUS_ONE;
        n_res.bary_w = C_MINUS_ONE;
        n_res.dist_t = C_MINUS_ONE;
        if (r_side_par[DL-1]) begin
            n_status = ST_PARALLEL;
        end else if ((u_e < -eps_e) || (u_e > ONE_E + eps_e)) begin
            n_status     = ST_U_OUT;
            n_res.bary_u = quo_u;
        end else if ((v_e < -eps_e) || (u_e + v_e > ONE_E + eps_e)) begin
            n_status     = ST_V_OUT;
            n_res.bary_u = quo_u;
            n_res.bary_v = quo_v;
        end else begin
            n_status     = (t_e > eps_e) ? ST_HIT : ST_BEHIND;
            n_res.bary_u = quo_u;
            n_res.bary_v = quo_v;
            n_res.bary_w = n_w;
            n_res.dist_t = quo_t;
        end
        n_res.status = n_status;
        n_res.hit    = n_status == ST_HIT;
    end

    t_result r_res;
    logic    r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_side_vld[DL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

/* bench/ray_triangle_barycentric_test_top_test.sv */
module ray_triangle_barycentric_test_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rtbt_pkg::*;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        t_tri_in item;
        bit      known;
        t_result res;
    } t_row;

    localparam longint FX = 65536;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    t_tri_in                  i_tri;
    logic                     i_cfg_we;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_idx;
    logic [COORD_WIDTH-1:0]   i_cfg_data;
    logic                     busy;
    logic                     o_strobe;
    t_result                  o_res;

    longint  ray_org[3];
    longint  ray_dir[3];
    longint  ray_eps;
    t_result hit_queue[$];
    int      err_cnt;
    int      idle_pct;
    t_row    rows[$];

    ray_triangle_barycentric_test_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_tri      (i_tri),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .busy       (busy),
        .o_strobe   (o_strobe),
        .o_res      (o_res)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic t_wide wide(longint x);
        return x;
    endfunction

    function automatic longint clamp(t_wide x);
        if (x > wide(C_MAX)) return C_MAX;
        if (x < wide(C_MIN)) return C_MIN;
        return longint'(x);
    endfunction

    function automatic longint cross_fix(longint a1, longint b2, longint a2, longint b1);
        t_wide d;
        d = wide(a1) * wide(b2) - wide(a2) * wide(b1);
        return clamp(d >>> FRAC_BITS);
    endfunction

    function automatic t_wide dot_exact(longint x0, longint x1, longint x2,
                                        longint y0, longint y1, longint y2);
        return wide(x0) * wide(y0) + wide(x1) * wide(y1) + wide(x2) * wide(y2);
    endfunction

    function automatic longint quot(t_wide num, longint den);
        return clamp(num / wide(den));
    endfunction

    function automatic t_result tri_predict(t_tri_in tr);
        longint  v0[3], e1[3], e2[3], s[3], h[3], q[3];
        longint  a, u, v, w, t, one;
        t_status st;
        t_result r;
        v0[0] = tr.vert0_x; v0[1] = tr.vert0_y; v0[2] = tr.vert0_z;
        e1[0] = clamp(wide(tr.vert1_x) - wide(v0[0]));
        e1[1] = clamp(wide(tr.vert1_y) - wide(v0[1]));
        e1[2] = clamp(wide(tr.vert1_z) - wide(v0[2]));
        e2[0] = clamp(wide(tr.vert2_x) - wide(v0[0]));
        e2[1] = clamp(wide(tr.vert2_y) - wide(v0[1]));
        e2[2] = clamp(wide(tr.vert2_z) - wide(v0[2]));
        for (int i = 0; i < 3; i++) s[i] = clamp(wide(ray_org[i]) - wide(v0[i]));
        one = FX;
        u = -one; v = -one; w = -one; t = -one;
        h[0] = cross_fix(ray_dir[1], e2[2], ray_dir[2], e2[1]);
        h[1] = cross_fix(ray_dir[2], e2[0], ray_dir[0], e2[2]);
        h[2] = cross_fix(ray_dir[0], e2[1], ray_dir[1], e2[0]);
        a = clamp(dot_exact(e1[0], e1[1], e1[2], h[0], h[1], h[2]) >>> FRAC_BITS);
        if (a == 0 || (a > -ray_eps && a < ray_eps)) begin
            st = ST_PARALLEL;
        end else begin
            u = quot(dot_exact(s[0], s[1], s[2], h[0], h[1], h[2]), a);
            if (u < -ray_eps || u > one + ray_eps) begin
                st = ST_U_OUT;
            end else begin
                q[0] = cross_fix(s[1], e1[2], s[2], e1[1]);
                q[1] = cross_fix(s[2], e1[0], s[0], e1[2]);
                q[2] = cross_fix(s[0], e1[1], s[1], e1[0]);
                v = quot(dot_exact(ray_dir[0], ray_dir[1], ray_dir[2],
                                   q[0], q[1], q[2]), a);
                if (v < -ray_eps || u + v > one + ray_eps) begin
                    st = ST_V_OUT;
                end else begin
                    w = clamp(wide(one) - wide(u) - wide(v));
                    t = quot(dot_exact(e2[0], e2[1], e2[2], q[0], q[1], q[2]), a);
                    st = (t > ray_eps) ? ST_HIT : ST_BEHIND;
                end
            end
        end
        r.hit    = (st == ST_HIT);
        r.status = st;
        r.bary_u = t_coord'(u);
        r.bary_v = t_coord'(v);
        r.bary_w = t_coord'(w);
        r.dist_t = t_coord'(t);
        return r;
    endfunction

    function automatic t_tri_in make_tri(longint ax, longint ay, longint az,
                                         longint bx, longint by, longint bz,
                                         longint cx, longint cy, longint cz);
        t_tri_in tr;
        tr.vert0_x = t_coord'(ax); tr.vert0_y = t_coord'(ay); tr.vert0_z = t_coord'(az);
        tr.vert1_x = t_coord'(bx); tr.vert1_y = t_coord'(by); tr.vert1_z = t_coord'(bz);
        tr.vert2_x = t_coord'(cx); tr.vert2_y = t_coord'(cy); tr.vert2_z = t_coord'(cz);
        return tr;
    endfunction

    function automatic t_result missed_parallel();
        t_result r;
        r.hit    = 1'b0;
        r.status = ST_PARALLEL;
        r.bary_u = C_MINUS_ONE;
        r.bary_v = C_MINUS_ONE;
        r.bary_w = C_MINUS_ONE;
        r.dist_t = C_MINUS_ONE;
        return r;
    endfunction

    function automatic void add_row(t_tri_in tr, bit known, t_result res);
        t_row row;
        row.item  = tr;
        row.known = known;
        row.res   = res;
        rows.insert(rows.size(), row);
    endfunction

    function automatic t_coord rand_coord();
        return t_coord'($urandom);
    endfunction

    function automatic longint jitter(longint range);
        return longint'($urandom_range(2 * range)) - range;
    endfunction

    // Well-formed triangles sit around a point on the ray, so most of them get
    // past the parallel and range tests; the rest is small or raw noise.
    function automatic t_tri_in rand_tri();
        longint c[3], k, sp;
        int     pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            return make_tri(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                            rand_coord());
        end
        if (pick < 40) begin
            return make_tri(jitter(1 << 20), jitter(1 << 20), jitter(1 << 20),
                            jitter(1 << 20), jitter(1 << 20), jitter(1 << 20),
                            jitter(1 << 20), jitter(1 << 20), jitter(1 << 20));
        end
        k  = longint'($urandom_range(6)) - 1;
        sp = longint'(1) << $urandom_range(20, 12);
        for (int i = 0; i < 3; i++) c[i] = clamp(wide(ray_org[i]) + wide(ray_dir[i]) * k);
        return make_tri(c[0] + jitter(sp), c[1] + jitter(sp), c[2] + jitter(sp),
                        c[0] + jitter(sp), c[1] + jitter(sp), c[2] + jitter(sp),
                        c[0] + jitter(sp), c[1] + jitter(sp), c[2] + jitter(sp));
    endfunction

    task automatic cfg_write(t_cfg_idx idx, logic [COORD_WIDTH-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        if (idx == CFG_EPSILON) ray_eps = data[EPS_WIDTH-1:0];
        else if (idx >= CFG_DIR_X) ray_dir[idx - CFG_DIR_X] = t_coord'(data);
        else ray_org[idx] = t_coord'(data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // The request stays up after the accepting edge, so that the next call can
    // present another one at the following falling edge without a gap.
    task automatic send_tri(t_tri_in tr, bit known, t_result res);
        t_result exp_res;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_tri = tr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        exp_res = known ? res : tri_predict(tr);
        hit_queue.insert(hit_queue.size(), exp_res);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (hit_queue.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) $display("Unexpected result %p", o_res);
            end else begin
                want = hit_queue.pop_front();
                if (o_res.hit !== want.hit || o_res.status !== want.status ||
                    o_res.bary_u !== want.bary_u || o_res.bary_v !== want.bary_v ||
                    o_res.bary_w !== want.bary_w || o_res.dist_t !== want.dist_t) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("Mismatch: expected %p", want);
                        $display("          actual   %p", o_res);
                    end
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_result none;
        none       = '0;
        err_cnt    = 0;
        idle_pct   = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_tri      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_ORIGIN_X;
        i_cfg_data = '0;
        ray_org    = '{0, 0, 0};
        ray_dir    = '{FX, 0, 0};
        ray_eps    = 7;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Degenerate triangles are parallel to any ray.
        add_row(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, missed_parallel());
        add_row(make_tri(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                         C_MAX), 1, missed_parallel());
        add_row(make_tri(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                         C_MIN), 1, missed_parallel());
        add_row(make_tri(2*FX, -FX, -FX, 2*FX, 2*FX, -FX, 2*FX, -FX, 2*FX), 0, none);
        add_row(make_tri(-2*FX, -FX, -FX, -2*FX, 2*FX, -FX, -2*FX, -FX, 2*FX), 0, none);
        add_row(make_tri(2*FX, 5*FX, -FX, 2*FX, 8*FX, -FX, 2*FX, 5*FX, 2*FX), 0, none);
        add_row(make_tri(2*FX, -FX, 5*FX, 2*FX, 2*FX, 5*FX, 2*FX, -FX, 8*FX), 0, none);
        add_row(make_tri(2*FX, -3*FX, -FX, 2*FX, FX, -FX, 2*FX, -FX, 3*FX), 0, none);
        add_row(make_tri(0, 0, 0, FX, 0, 0, 0, 0, FX), 0, none);
        add_row(make_tri(2*FX, 0, 0, 2*FX, FX, 0, 2*FX, 0, FX), 0, none);
        add_row(make_tri(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN,
                         C_MAX), 0, none);
        add_row(make_tri(C_MAX, C_MIN, 0, C_MIN, C_MAX, C_MIN, 0, C_MAX, C_MIN), 0, none);
        add_row(make_tri(FX, -FX, -FX, FX + 3, FX, -FX, FX, -FX, FX), 0, none);
        foreach (rows[i]) send_tri(rows[i].item, rows[i].known, rows[i].res);

        for (int ph = 0; ph < 9; ph++) begin
            drain();
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 74;
                default: idle_pct = 27;
            endcase
            if (ph == 1) begin
                for (int i = 0; i < 6; i++) cfg_write(t_cfg_idx'(i), C_MAX);
                cfg_write(CFG_EPSILON, 32'hFFFF);
            end else if (ph == 2) begin
                for (int i = 0; i < 3; i++) cfg_write(t_cfg_idx'(i), C_MIN);
                for (int i = 3; i < 6; i++) cfg_write(t_cfg_idx'(i), C_MIN);
                cfg_write(CFG_EPSILON, 32'h0);
            end else if (ph == 3) begin
                for (int i = 0; i < 6; i++) cfg_write(t_cfg_idx'(i), $urandom);
                cfg_write(CFG_EPSILON, $urandom);
            end else if (ph > 3) begin
                for (int i = 0; i < 3; i++) cfg_write(t_cfg_idx'(i), 32'(jitter(1 << 20)));
                for (int i = 3; i < 6; i++) cfg_write(t_cfg_idx'(i), 32'(jitter(1 << 17)));
                cfg_write(CFG_EPSILON, {16'hFFFF, 16'($urandom_range(ph * 8))});
            end
            for (int n = 0; n < 180; n++) send_tri(rand_tri(), 0, none);
        end
        drain();

        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
